### src/kmbs_pkg.sv
// Package for the knob mode selector and backlight smoother.
// Sizes, event codes, smoother and sigmoid-table constants, ROM read type.
// No dependencies.
package kmbs_pkg;

  // Converter sample width and fraction width of the smoothed level
  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 20;
  localparam int LEVEL_W       = SAMPLE_BITS + FRACTION_BITS;

  // Event codes on the request channel
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_BRIGHT = 2'd1;
  localparam logic [1:0] KIND_VOLUME = 2'd2;

  // Smoothing steps, Q0.24
  localparam int              ALPHA_BITS = 24;
  localparam int              ALPHA_W    = 15;
  localparam logic [ALPHA_W-1:0] ALPHA_SLOW = ALPHA_W'(1678);
  localparam logic [ALPHA_W-1:0] ALPHA_FAST = ALPHA_W'(16777);

  // Sigmoid table: 4096 entries, Q12.20
  localparam int ROM_AW    = 12;
  localparam int ROM_DEPTH = 1 << ROM_AW;
  localparam int ROM_W     = 32;
  localparam int ROM_FRAC  = 20;

  // Light sample to table index, table entry to level scale
  localparam int IDX_UP    = (SAMPLE_BITS >= ROM_AW) ? 0 : (ROM_AW - SAMPLE_BITS);
  localparam int IDX_DN    = (SAMPLE_BITS >= ROM_AW) ? (SAMPLE_BITS - ROM_AW) : 0;
  localparam int NET_SHIFT = FRACTION_BITS - ROM_FRAC + SAMPLE_BITS - ROM_AW;
  localparam int TGT_UP    = (NET_SHIFT > 0) ? NET_SHIFT : 0;
  localparam int TGT_DN    = (NET_SHIFT < 0) ? -NET_SHIFT : 0;

  // Table build: exponential in Q30, quotient (4000 << 50) / (2^30 + e)
  localparam int                  SIG_Q    = 30;
  localparam longint unsigned     Q30      = 64'd1 << SIG_Q;
  localparam int                  SIG_RL_W = 22;
  localparam logic [SIG_RL_W-1:0] SIG_RL   =
    SIG_RL_W'(Q30 / 400 + Q30 / 320000 + Q30 / 384000000);
  localparam int E_W    = 38;
  localparam int E_LO_W = 19;
  localparam int E_HI_W = E_W - E_LO_W;
  localparam int DIV_W  = 39;
  localparam int Q_W    = 32;
  localparam int SIG_NUM_SHIFT = 50;
  localparam logic [DIV_W-1:0]  SIG_NUM_HI = DIV_W'(64'd4000 << (SIG_NUM_SHIFT - Q_W));
  localparam logic [ROM_W-1:0]  SIG_FULL   = ROM_W'(64'd4000 << ROM_FRAC);
  localparam logic [ROM_AW-1:0] SIG_MID    = ROM_AW'(ROM_DEPTH / 2);

  typedef struct packed {
    logic              en;
    logic [ROM_AW-1:0] addr;
  } rom_rd_t;

endpackage

### src/kmbs_req_if.sv
// Request channel: one beat per PWM tick or button press.
// Depends on kmbs_pkg.
interface kmbs_req_if;
  import kmbs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [SAMPLE_BITS-1:0] knob_sample;
  logic [SAMPLE_BITS-1:0] light_sample;

  modport source (output valid, kind, knob_sample, light_sample, input ready);
  modport sink   (input valid, kind, knob_sample, light_sample, output ready);
endinterface

### src/kmbs_status_if.sv
// Status channel: one beat per request, state after that request.
// Depends on kmbs_pkg.
interface kmbs_status_if;
  import kmbs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pwm_level;
  logic                   knob_is_volume;
  logic                   adaptive_on;
  logic                   volume_ramp_on;
  logic [SAMPLE_BITS-1:0] volume_setting;
  logic [SAMPLE_BITS-1:0] brightness_setting;

  modport source (output valid, pwm_level, knob_is_volume, adaptive_on, volume_ramp_on,
                  volume_setting, brightness_setting, input ready);
  modport sink   (input valid, pwm_level, knob_is_volume, adaptive_on, volume_ramp_on,
                  volume_setting, brightness_setting, output ready);
endinterface

### src/kmbs_sig_rom.sv
// Sigmoid table memory with its build sequencer and one registered read port.
// Depends on kmbs_pkg.
module kmbs_sig_rom (
  input  logic                        clk,
  input  logic                        rst,
  input  kmbs_pkg::rom_rd_t           rd,
  output logic [kmbs_pkg::ROM_W-1:0]  rd_data,
  output logic                        ready
);
  import kmbs_pkg::*;

  localparam int CNT_W  = $clog2(Q_W);
  localparam int PLO_W  = E_LO_W + SIG_RL_W;
  localparam int PHI_W  = E_HI_W + SIG_RL_W;
  localparam int PROD_W = E_W + SIG_RL_W;

  typedef enum logic [1:0] {BUILD_DIV, BUILD_WR_HI, BUILD_WR_LO, BUILD_DONE} build_state_t;

  build_state_t      state;
  logic [ROM_AW-1:0] d;
  logic [CNT_W-1:0]  bit_cnt;
  logic [E_W-1:0]    e;
  logic [PLO_W-1:0]  p_lo_q;
  logic [DIV_W-1:0]  dvsr;
  logic [DIV_W-1:0]  rem;
  logic [Q_W-1:0]    quo;

  logic [ROM_W-1:0]  mem [ROM_DEPTH];

  logic [DIV_W:0]    rem_sh;
  logic              take;
  logic [DIV_W-1:0]  rem_next;
  logic [PHI_W-1:0]  p_hi;
  logic [PROD_W-1:0] prod_sum;
  logic [E_W-1:0]    e_next;
  logic              wr_en;
  logic [ROM_AW-1:0] wr_addr;
  logic [ROM_W-1:0]  wr_data;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, 1'b0};
    take     = rem_sh >= {1'b0, dvsr};
    rem_next = take ? DIV_W'(rem_sh - {1'b0, dvsr}) : DIV_W'(rem_sh);
  end

  // e += (e * r) >> 30, split into two partial products; the low one is registered first
  always_comb begin
    p_hi     = e[E_W-1:E_LO_W] * SIG_RL;
    prod_sum = {p_hi, {E_LO_W{1'b0}}} + PROD_W'(p_lo_q);
    e_next   = e + E_W'(prod_sum >> SIG_Q);
  end

  // upper half gets y, lower half gets full scale minus y
  always_comb begin
    wr_en   = ((state == BUILD_WR_HI) && !d[ROM_AW-1]) ||
              ((state == BUILD_WR_LO) && (d != '0));
    wr_addr = (state == BUILD_WR_HI) ? ROM_AW'(SIG_MID + d) : ROM_AW'(SIG_MID - d);
    wr_data = (state == BUILD_WR_HI) ? quo : ROM_W'(SIG_FULL - quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BUILD_DIV;
      d       <= '0;
      bit_cnt <= '0;
      e       <= E_W'(Q30);
      dvsr    <= DIV_W'(Q30 + Q30);
      rem     <= SIG_NUM_HI;
      ready   <= 1'b0;
    end else begin
      unique case (state)
        BUILD_DIV: begin
          rem     <= rem_next;
          quo     <= {quo[Q_W-2:0], take};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == CNT_W'(0)) p_lo_q <= e[E_LO_W-1:0] * SIG_RL;
          if (bit_cnt == CNT_W'(1)) e <= e_next;
          if (bit_cnt == CNT_W'(Q_W - 1)) state <= BUILD_WR_HI;
        end
        BUILD_WR_HI: state <= BUILD_WR_LO;
        BUILD_WR_LO: begin
          if (d == SIG_MID) begin
            state <= BUILD_DONE;
            ready <= 1'b1;
          end else begin
            d       <= d + 1'b1;
            dvsr    <= DIV_W'(Q30) + DIV_W'(e);
            rem     <= SIG_NUM_HI;
            bit_cnt <= '0;
            state   <= BUILD_DIV;
          end
        end
        BUILD_DONE: ;
        default: state <= BUILD_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd.en) rd_data <= mem[rd.addr];
  end

endmodule

### src/knob_mode_and_backlight_smoother.sv
// Top level of the knob mode selector and backlight smoother.
// Depends on kmbs_pkg, kmbs_req_if, kmbs_status_if and kmbs_sig_rom.
//
// Usage
//   request: one beat per event (kind: PWM tick, brightness press, volume
//     press; kind 3 is a no-op) with the latest knob and light readings.
//   status: one beat per request beat, in order, showing the state after
//     that event: integer backlight level, mode flags and both settings.
//   Path: the request beat is registered together with its sigmoid read,
//     then the smoother writes the result register that drives status.
//   Throughput: one beat per cycle unless status stalls. The state update is a pass of
//     one 33x16 multiply and an add, so beats may arrive back to back.
//   Reset: all mode state goes to reset values, then the sigmoid table is
//     rebuilt by a serial divider, 2049 points, each a divide followed by its
//     mirrored table writes. request.ready stays low until the table is done.
//   Stall: when status.ready is low the result register holds, one more
//     beat can sit in the request register, then request.ready drops.
module knob_mode_and_backlight_smoother (
  input logic         clk,
  input logic         rst,
  kmbs_req_if.sink    request,
  kmbs_status_if.source status
);
  import kmbs_pkg::*;

  localparam int TGT_W  = ROM_W + TGT_UP;
  localparam int IDX_W  = SAMPLE_BITS + IDX_UP;
  localparam int PROD_W = LEVEL_W + ALPHA_W + 2;

  // table
  rom_rd_t          rd;
  logic [ROM_W-1:0] rom_q;
  logic             rom_ready;

  // request stage
  logic                   a_valid;
  logic [1:0]             a_kind;
  logic [SAMPLE_BITS-1:0] a_knob;

  // block state
  logic                   volume_sel;
  logic                   adaptive_enable;
  logic                   ramp_enable;
  logic [SAMPLE_BITS-1:0] saved_volume;
  logic [SAMPLE_BITS-1:0] saved_brightness;
  logic [LEVEL_W-1:0]     level;

  logic                   volume_sel_next;
  logic                   adaptive_enable_next;
  logic                   ramp_enable_next;
  logic [SAMPLE_BITS-1:0] saved_volume_next;
  logic [SAMPLE_BITS-1:0] saved_brightness_next;
  logic [LEVEL_W-1:0]     level_next;

  // result register
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] pwm_level;
  logic                   knob_is_volume;
  logic                   adaptive_on;
  logic                   volume_ramp_on;
  logic [SAMPLE_BITS-1:0] volume_setting;
  logic [SAMPLE_BITS-1:0] brightness_setting;

  logic                   advance;
  logic                   accept;

  // smoother datapath
  logic [TGT_W-1:0]          t_wide;
  logic [LEVEL_W-1:0]        target;
  logic [ALPHA_W-1:0]        alpha;
  logic signed [LEVEL_W:0]   diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  step;
  logic [LEVEL_W-1:0]        smoothed;

  // the request stage moves on when the result register is free or draining
  assign advance       = a_valid && (!out_valid || status.ready);
  assign request.ready = rom_ready && (!a_valid || advance);
  assign accept        = request.valid && request.ready;

  // sigmoid lookup issued with the request beat; data lines up with stage A
  assign rd.en   = accept;
  assign rd.addr = ROM_AW'((IDX_W'(request.light_sample) << IDX_UP) >> IDX_DN);

  kmbs_sig_rom u_sig_rom (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .rd_data (rom_q),
    .ready   (rom_ready)
  );

  // new = s + floor((t - s) * a / 2^24), same as the weighted sum form
  always_comb begin
    t_wide = (TGT_W'(rom_q) << TGT_UP) >> TGT_DN;
    if (adaptive_enable) begin
      target = LEVEL_W'(t_wide);
      alpha  = ALPHA_SLOW;
    end else begin
      target = {(volume_sel ? saved_brightness : a_knob), {FRACTION_BITS{1'b0}}};
      alpha  = ALPHA_FAST;
    end
    diff     = $signed({1'b0, target}) - $signed({1'b0, level});
    prod     = diff * $signed({1'b0, alpha});
    step     = prod >>> ALPHA_BITS;
    smoothed = level + LEVEL_W'(step);
  end

  always_comb begin
    volume_sel_next       = volume_sel;
    adaptive_enable_next  = adaptive_enable;
    ramp_enable_next      = ramp_enable;
    saved_volume_next     = saved_volume;
    saved_brightness_next = saved_brightness;
    level_next            = level;
    unique case (a_kind)
      KIND_TICK: level_next = smoothed;
      KIND_BRIGHT: begin
        // a brightness press in brightness mode flips adaptive
        if (!volume_sel) begin
          adaptive_enable_next = !adaptive_enable;
        end else begin
          saved_volume_next = a_knob;
          volume_sel_next   = 1'b0;
        end
      end
      KIND_VOLUME: begin
        if (volume_sel) begin
          ramp_enable_next = !ramp_enable;
        end else begin
          saved_brightness_next = a_knob;
          volume_sel_next       = 1'b1;
        end
      end
      default: ;  // unused code: state unchanged, status still sent
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid          <= 1'b0;
      out_valid        <= 1'b0;
      volume_sel       <= 1'b0;
      adaptive_enable  <= 1'b1;
      ramp_enable      <= 1'b1;
      saved_volume     <= '1;
      saved_brightness <= '0;
      level            <= '0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        volume_sel       <= volume_sel_next;
        adaptive_enable  <= adaptive_enable_next;
        ramp_enable      <= ramp_enable_next;
        saved_volume     <= saved_volume_next;
        saved_brightness <= saved_brightness_next;
        level            <= level_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind <= request.kind;
      a_knob <= request.knob_sample;
    end
    if (advance) begin
      pwm_level          <= level_next[LEVEL_W-1:FRACTION_BITS];
      knob_is_volume     <= volume_sel_next;
      adaptive_on        <= adaptive_enable_next;
      volume_ramp_on     <= ramp_enable_next;
      volume_setting     <= volume_sel_next ? a_knob : saved_volume_next;
      brightness_setting <= volume_sel_next ? saved_brightness_next : a_knob;
    end
  end

  assign status.valid              = out_valid;
  assign status.pwm_level          = pwm_level;
  assign status.knob_is_volume     = knob_is_volume;
  assign status.adaptive_on        = adaptive_on;
  assign status.volume_ramp_on     = volume_ramp_on;
  assign status.volume_setting     = volume_setting;
  assign status.brightness_setting = brightness_setting;

  // button beats never move the backlight level
  a_press_holds_level: assert property (@(posedge clk) disable iff (rst)
    (advance && (a_kind != KIND_TICK)) |=> (level == $past(level)))
    else $error("backlight level moved on a button beat");

  // leaving brightness mode saves the knob as the brightness
  a_volume_press_saves: assert property (@(posedge clk) disable iff (rst)
    (advance && (a_kind == KIND_VOLUME) && !volume_sel) |=>
    (volume_sel && (saved_brightness == $past(a_knob))))
    else $error("volume press from brightness mode did not save knob");

  // both stages full and stalled: no room for another beat
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (a_valid && out_valid && !status.ready) |-> !request.ready)
    else $error("request taken with both stages full and stalled");

  // a result only appears after a request stage beat moved on
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("status beat without a request beat");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for knob_mode_and_backlight_smoother: directed table, then random events in
// four flow-control phases; status beats checked against typed rows or a local predictor.
// Depends on kmbs_pkg, kmbs_req_if, kmbs_status_if and the RTL top level.
module tb;
  import kmbs_pkg::*;

  // No-op event: the package names only the three live codes
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int RANDOM_PER_PHASE = 432;  // four phases, ~1750 events with the table
  localparam int DRAIN_LIMIT      = 10000;
  localparam int REPORT_MAX       = 10;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pwm_level;
    logic                   knob_is_volume;
    logic                   adaptive_on;
    logic                   volume_ramp_on;
    logic [SAMPLE_BITS-1:0] volume_setting;
    logic [SAMPLE_BITS-1:0] brightness_setting;
  } status_t;

  // One directed event; want is only used when typed is set
  typedef struct packed {
    logic [1:0]             kind;
    logic [SAMPLE_BITS-1:0] knob;
    logic [SAMPLE_BITS-1:0] light;
    logic                   typed;
    status_t                want;
  } event_row_t;

  localparam status_t UNTYPED = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kmbs_req_if    request ();
  kmbs_status_if status ();

  knob_mode_and_backlight_smoother dut (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .status  (status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: mode flags, saved settings, Q12.20 smoothed level, sigmoid table
  // ---------------------------------------------------------------------------
  longint unsigned sigmoid_q20 [ROM_DEPTH];
  logic            mode_is_volume;
  logic            adaptive_en;
  logic            ramp_en;
  logic [SAMPLE_BITS-1:0] kept_volume;
  logic [SAMPLE_BITS-1:0] kept_brightness;
  longint unsigned level_q;

  // 4000 / (1 + e^((x-2048)/400)) in Q20. The exponential is grown step by step
  // in Q30; the lower half mirrors the upper half around 2000.
  function automatic void build_sigmoid_table();
    longint unsigned one_q30, rate, expo, quot, full;
    one_q30 = 64'd1 << 30;
    rate    = one_q30 / 400 + one_q30 / 320000 + one_q30 / 384000000;
    full    = 64'd4000 << ROM_FRAC;
    expo    = one_q30;
    for (int d = 0; d <= ROM_DEPTH / 2; d++) begin
      quot = (64'd4000 << 50) / (one_q30 + expo);
      if (d < ROM_DEPTH / 2) sigmoid_q20[ROM_DEPTH / 2 + d] = quot & 64'hFFFF_FFFF;
      if (d > 0) sigmoid_q20[ROM_DEPTH / 2 - d] = (full - quot) & 64'hFFFF_FFFF;
      expo = expo + ((expo * rate) >> 30);
    end
  endfunction

  function automatic void clear_backlight_state();
    mode_is_volume  = 1'b0;
    adaptive_en     = 1'b1;
    ramp_en         = 1'b1;
    kept_volume     = '1;
    kept_brightness = '0;
    level_q         = 0;
  endfunction

  // Applies one event and returns the status it should produce
  function automatic status_t backlight_step(logic [1:0] kind,
                                             logic [SAMPLE_BITS-1:0] knob,
                                             logic [SAMPLE_BITS-1:0] light);
    longint unsigned target, alpha, idx, lt;
    status_t s;
    lt = light;
    case (kind)
      KIND_TICK: begin
        if (adaptive_en) begin
          idx    = ((lt << IDX_UP) >> IDX_DN) & (ROM_DEPTH - 1);
          target = (sigmoid_q20[idx] << TGT_UP) >> TGT_DN;
          alpha  = ALPHA_SLOW;
        end else begin
          target = longint'(mode_is_volume ? kept_brightness : knob) << FRACTION_BITS;
          alpha  = ALPHA_FAST;
        end
        level_q = (level_q * ((64'd1 << ALPHA_BITS) - alpha) + target * alpha) >> ALPHA_BITS;
      end
      KIND_BRIGHT: begin
        if (!mode_is_volume) begin
          adaptive_en = !adaptive_en;
        end else begin
          kept_volume    = knob;
          mode_is_volume = 1'b0;
        end
      end
      KIND_VOLUME: begin
        if (mode_is_volume) begin
          ramp_en = !ramp_en;
        end else begin
          kept_brightness = knob;
          mode_is_volume  = 1'b1;
        end
      end
      default: ;  // no-op code, state holds
    endcase
    s.pwm_level          = SAMPLE_BITS'(level_q >> FRACTION_BITS);
    s.knob_is_volume     = mode_is_volume;
    s.adaptive_on        = adaptive_en;
    s.volume_ramp_on     = ramp_en;
    s.volume_setting     = mode_is_volume ? knob : kept_volume;
    s.brightness_setting = mode_is_volume ? kept_brightness : knob;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  status_t status_due [$];    // expected status beats, oldest first
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int failures       = 0;
  int beats_checked  = 0;
  int events_sent    = 0;
  int ticks_sent     = 0;
  int presses_sent   = 0;
  int peak_pwm       = 0;
  status_t got;
  status_t due;

  // ---------------------------------------------------------------------------
  // Request side: gaps at random, valid held high across back-to-back beats.
  // Called at a falling edge, returns at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [1:0] kind, input logic [SAMPLE_BITS-1:0] knob,
                            input logic [SAMPLE_BITS-1:0] light, input logic typed,
                            input status_t want);
    status_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      request.valid <= 1'b0;
      @(negedge clk);
    end
    request.valid        <= 1'b1;
    request.kind         <= kind;
    request.knob_sample  <= knob;
    request.light_sample <= light;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    // beat accepted at this edge
    predicted = backlight_step(kind, knob, light);
    status_due.push_back(typed ? want : predicted);
    if (kind == KIND_TICK) ticks_sent++;
    else if (kind == KIND_BRIGHT || kind == KIND_VOLUME) presses_sent++;
    if (kind != KIND_NONE) events_sent++;
    @(negedge clk);
  endtask

  // Random events in runs: each run keeps a knob and light level for most ticks
  // so the smoother gets time to travel, with presses and no-ops sprinkled in.
  task automatic random_events(input int count);
    int start, run_len, pick;
    logic [SAMPLE_BITS-1:0] knob_base, light_base, knob, light;
    logic [1:0] kind;
    start = events_sent;
    while (events_sent - start < count) begin
      run_len = $urandom_range(200, 10);
      case ($urandom_range(3))
        0:       knob_base = '0;
        1:       knob_base = '1;
        default: knob_base = SAMPLE_BITS'($urandom_range(4095));
      endcase
      case ($urandom_range(3))
        0:       light_base = '0;
        1:       light_base = '1;
        default: light_base = SAMPLE_BITS'($urandom_range(4095));
      endcase
      for (int i = 0; i < run_len && events_sent - start < count; i++) begin
        pick  = $urandom_range(99);
        knob  = ($urandom_range(9) < 8) ? knob_base : SAMPLE_BITS'($urandom_range(4095));
        light = ($urandom_range(9) < 8) ? light_base : SAMPLE_BITS'($urandom_range(4095));
        if (pick < 86)      kind = KIND_TICK;
        else if (pick < 92) kind = KIND_BRIGHT;
        else if (pick < 98) kind = KIND_VOLUME;
        else                kind = KIND_NONE;
        send_event(kind, knob, light, 1'b0, UNTYPED);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Status side: stall at the falling edge, check each accepted beat at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    status.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && status.valid && status.ready) begin
      got = {status.pwm_level, status.knob_is_volume, status.adaptive_on,
             status.volume_ramp_on, status.volume_setting, status.brightness_setting};
      if (status_due.size() == 0) begin
        if (failures < REPORT_MAX)
          $display("%0t: status beat with nothing expected (pwm %0d)", $realtime, got.pwm_level);
        failures++;
      end else begin
        due = status_due.pop_front();
        beats_checked++;
        if (got.pwm_level > peak_pwm) peak_pwm = got.pwm_level;
        if (got !== due) begin
          if (failures < REPORT_MAX) begin
            $display("%0t: status mismatch, expected / actual:", $realtime);
            $display("  pwm %0d / %0d  vol %b / %b  adapt %b / %b  ramp %b / %b",
                     due.pwm_level, got.pwm_level, due.knob_is_volume, got.knob_is_volume,
                     due.adaptive_on, got.adaptive_on, due.volume_ramp_on, got.volume_ramp_on);
            $display("  volume %0d / %0d  brightness %0d / %0d",
                     due.volume_setting, got.volume_setting,
                     due.brightness_setting, got.brightness_setting);
          end
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Opening table. Status is typed in for the button and no-op rows before the
  // first tick, where the level is still zero; tick rows go to the predictor.
  event_row_t opening [23];

  initial begin
    request.valid        = 1'b0;
    request.kind         = KIND_TICK;
    request.knob_sample  = '0;
    request.light_sample = '0;

    opening = '{
      // no-op right after reset: reset values, brightness shows the knob
      {KIND_NONE,   12'd0,    12'd0,    1'b1, {12'd0, 1'b0, 1'b1, 1'b1, 12'd4095, 12'd0}},
      {KIND_NONE,   12'd4095, 12'd4095, 1'b1, {12'd0, 1'b0, 1'b1, 1'b1, 12'd4095, 12'd4095}},
      // brightness press in brightness mode flips adaptive off, then on
      {KIND_BRIGHT, 12'd100,  12'd0,    1'b1, {12'd0, 1'b0, 1'b0, 1'b1, 12'd4095, 12'd100}},
      {KIND_BRIGHT, 12'd200,  12'd4095, 1'b1, {12'd0, 1'b0, 1'b1, 1'b1, 12'd4095, 12'd200}},
      // volume press in brightness mode saves brightness, enters volume mode
      {KIND_VOLUME, 12'd1234, 12'd0,    1'b1, {12'd0, 1'b1, 1'b1, 1'b1, 12'd1234, 12'd1234}},
      // volume press in volume mode flips the ramp off, then on
      {KIND_VOLUME, 12'd0,    12'd0,    1'b1, {12'd0, 1'b1, 1'b1, 1'b0, 12'd0,    12'd1234}},
      {KIND_VOLUME, 12'd4095, 12'd0,    1'b1, {12'd0, 1'b1, 1'b1, 1'b1, 12'd4095, 12'd1234}},
      {KIND_NONE,   12'd77,   12'd0,    1'b1, {12'd0, 1'b1, 1'b1, 1'b1, 12'd77,   12'd1234}},
      // brightness press in volume mode saves volume, back to brightness mode
      {KIND_BRIGHT, 12'd2222, 12'd0,    1'b1, {12'd0, 1'b0, 1'b1, 1'b1, 12'd2222, 12'd2222}},
      // adaptive ticks: both table ends and the middle
      {KIND_TICK,   12'd0,    12'd0,    1'b0, UNTYPED},
      {KIND_TICK,   12'd0,    12'd4095, 1'b0, UNTYPED},
      {KIND_TICK,   12'd4095, 12'd2048, 1'b0, UNTYPED},
      {KIND_TICK,   12'd4095, 12'd2047, 1'b0, UNTYPED},
      // manual ticks toward the knob extremes
      {KIND_BRIGHT, 12'd4095, 12'd0,    1'b0, UNTYPED},
      {KIND_TICK,   12'd4095, 12'd0,    1'b0, UNTYPED},
      {KIND_TICK,   12'd0,    12'd4095, 1'b0, UNTYPED},
      // manual ticks in volume mode chase the saved brightness
      {KIND_VOLUME, 12'd3000, 12'd0,    1'b0, UNTYPED},
      {KIND_TICK,   12'd0,    12'd4095, 1'b0, UNTYPED},
      {KIND_TICK,   12'd4095, 12'd0,    1'b0, UNTYPED},
      {KIND_BRIGHT, 12'd0,    12'd0,    1'b0, UNTYPED},
      {KIND_NONE,   12'd4095, 12'd4095, 1'b0, UNTYPED},
      {KIND_BRIGHT, 12'd1,    12'd1,    1'b0, UNTYPED},
      {KIND_TICK,   12'd1,    12'd1,    1'b0, UNTYPED}
    };

    build_sigmoid_table();
    clear_backlight_state();

    // Reset once; afterwards request.ready stays low while the table is rebuilt
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening[i])
      send_event(opening[i].kind, opening[i].knob, opening[i].light,
                 opening[i].typed, opening[i].want);

    // Flow-control phases: none, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      random_events(RANDOM_PER_PHASE);
    end
    request.valid <= 1'b0;

    // Drain, then let the two-stage pipe settle in case a stray beat follows
    for (int n = 0; status_due.size() != 0 && n < DRAIN_LIMIT; n++) @(posedge clk);
    repeat (8) @(posedge clk);

    if (status_due.size() != 0)
      $display("%0d expected status beats never arrived", status_due.size());
    $display("Ran %0d events (%0d ticks, %0d presses) over four flow-control phases;",
             events_sent, ticks_sent, presses_sent);
    $display("checked %0d status beats, highest level %0d, %0d failures.",
             beats_checked, peak_pwm, failures);
    if (failures == 0 && status_due.size() == 0) begin
      $display("** knob_mode_and_backlight_smoother: PASSED **");
    end else begin
      $display("** knob_mode_and_backlight_smoother: FAILED **");
    end
    $finish;
  end

  // Watchdog: fails the run if the table rebuild and the traffic overrun the delay below
  initial begin
    #5_000_000;
    $display("** knob_mode_and_backlight_smoother: FAILED **");
    $finish;
  end

endmodule
